[src/mbat_pkg.sv]
// mbat_pkg: shared types and constants of the mac byte accounting table
// depends on nothing; used by the interfaces, the control unit and the top level

package mbat_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int MAC_W       = 48;
   localparam int LEN_W       = 16;
   localparam int TOTAL_W     = 32;
   localparam int RIDX_W      = 10;
   localparam int OIDX_W      = 10;
   localparam int OCNT_W      = 11;
   localparam int STATUS_W    = 3;
   localparam int CMP_W       = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

   localparam logic [MAC_W-1:0]   MAC_BROADCAST = '1;
   localparam logic [MAC_W-1:0]   VENDOR_MASK   = 48'hFFFF_FF00_0000;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX     = '1;

   // request operations
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_INSERTED    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_ACCUMULATED = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_BROADCAST   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_READ        = 3'd4;

   // control register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_RECEIVER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VENDOR_ONLY  = 1'd1;

   typedef struct packed {
      logic              operation;
      logic [MAC_W-1:0]  transmitter_mac;
      logic [MAC_W-1:0]  receiver_mac;
      logic [LEN_W-1:0]  byte_count;
      logic [RIDX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OIDX_W-1:0]   entry_index;
      logic [MAC_W-1:0]    entry_mac;
      logic [TOTAL_W-1:0]  entry_total;
      logic [OCNT_W-1:0]   entry_count;
      logic                index_invalid;
   } rsp_type;

   typedef struct packed {
      logic use_receiver;
      logic vendor_only;
   } cfg_type;

   // access to the key and total memories
   typedef struct packed {
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
      logic               key_we;
      logic               total_we;
      logic [IDX_W-1:0]   wr_addr;
      logic [MAC_W-1:0]   key_wdata;
      logic [TOTAL_W-1:0] total_wdata;
   } mem_req_type;

endpackage

[src/mbat_if.sv]
// mbat_if: request and response channel interfaces (valid/ready handshake)
// depends on mbat_pkg for the payload types

interface mbat_req_if import mbat_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mbat_rsp_if import mbat_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[src/mbat_ram.sv]
// mbat_ram: generic single-write, single-read memory with registered read data
// depends on nothing

module mbat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/mbat_ctrl.sv]
// mbat_ctrl: sequencer that scans the key memory, updates totals and appends entries
// depends on mbat_pkg; drives the key and total memories held in the top level

module mbat_ctrl import mbat_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   input  logic               emit_ok,
   output logic               emit_valid,
   output rsp_type            emit_data,
   output mem_req_type        mem,
   input  logic [MAC_W-1:0]   key_rdata,
   input  logic [TOTAL_W-1:0] total_rdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RDWAIT = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_HIT    = 3'd3;
   localparam logic [2:0] S_MISS   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [MAC_W-1:0]  key_ff, key_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   rsp_type           res_ff, res_in;

   logic               accept;
   logic               drop;
   logic [MAC_W-1:0]   key_sel;
   logic               ridx_ok;
   logic               match;
   logic               issue;
   logic               full;
   logic [TOTAL_W:0]   sum_wide;
   logic [TOTAL_W-1:0] sum_sat;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      key_sel = cfg.use_receiver ? req_data.receiver_mac : req_data.transmitter_mac;
      if (cfg.vendor_only) begin
         key_sel = key_sel & VENDOR_MASK;
      end
   end

   assign drop    = (req_data.transmitter_mac == MAC_BROADCAST) ||
                    (req_data.receiver_mac == MAC_BROADCAST);
   assign ridx_ok = CMP_W'(req_data.read_index) < CMP_W'(count_ff);

   // compare the entry read last cycle while the next one is fetched
   assign match = pend_ff && (key_rdata == key_ff);
   assign issue = !match && (ptr_ff < count_ff);
   assign full  = count_ff >= CNT_W'(TABLE_DEPTH);

   assign sum_wide = {1'b0, total_rdata} + (TOTAL_W + 1)'(len_ff);
   assign sum_sat  = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      pend_in    = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      key_in     = key_ff;
      len_in     = len_ff;
      res_in     = res_ff;
      emit_valid = 1'b0;
      emit_data  = res_ff;
      mem        = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in  = key_sel;
               len_in  = req_data.byte_count;
               ptr_in  = '0;
               res_in  = '0;
               res_in.entry_count = OCNT_W'(count_ff);
               if (req_data.operation == OP_READ) begin
                  res_in.status      = STAT_READ;
                  res_in.entry_index = OIDX_W'(req_data.read_index);
                  if (ridx_ok) begin
                     mem.rd_en   = 1'b1;
                     mem.rd_addr = IDX_W'(req_data.read_index);
                     state_in    = S_RDWAIT;
                  end else begin
                     res_in.index_invalid = 1'b1;
                     state_in             = S_DONE;
                  end
               end else if (drop) begin
                  res_in.status = STAT_BROADCAST;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_RDWAIT: begin
            emit_data.entry_mac   = key_rdata;
            emit_data.entry_total = total_rdata;
            if (emit_ok) begin
               emit_valid = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SCAN: begin
            mem.rd_en   = issue;
            mem.rd_addr = ptr_ff[IDX_W-1:0];
            if (issue) begin
               ptr_in     = ptr_ff + 1'b1;
               pend_in    = 1'b1;
               cmp_idx_in = ptr_ff[IDX_W-1:0];
            end
            if (match) begin
               state_in = S_HIT;
            end else if (!issue) begin
               state_in = S_MISS;
            end
         end
         S_HIT: begin
            emit_data.status        = STAT_ACCUMULATED;
            emit_data.entry_index   = OIDX_W'(cmp_idx_ff);
            emit_data.entry_mac     = key_ff;
            emit_data.entry_total   = sum_sat;
            emit_data.entry_count   = OCNT_W'(count_ff);
            emit_data.index_invalid = 1'b0;
            if (emit_ok) begin
               mem.total_we    = 1'b1;
               mem.wr_addr     = cmp_idx_ff;
               mem.total_wdata = sum_sat;
               emit_valid      = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_MISS: begin
            emit_data.entry_mac     = key_ff;
            emit_data.index_invalid = 1'b0;
            if (full) begin
               emit_data.status      = STAT_FULL;
               emit_data.entry_index = '0;
               emit_data.entry_total = '0;
               emit_data.entry_count = OCNT_W'(count_ff);
            end else begin
               emit_data.status      = STAT_INSERTED;
               emit_data.entry_index = OIDX_W'(count_ff);
               emit_data.entry_total = TOTAL_W'(len_ff);
               emit_data.entry_count = OCNT_W'(count_ff + 1'b1);
            end
            if (emit_ok) begin
               if (!full) begin
                  mem.key_we      = 1'b1;
                  mem.total_we    = 1'b1;
                  mem.wr_addr     = count_ff[IDX_W-1:0];
                  mem.key_wdata   = key_ff;
                  mem.total_wdata = TOTAL_W'(len_ff);
                  count_in        = count_ff + 1'b1;
               end
               emit_valid = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DONE: begin
            if (emit_ok) begin
               emit_valid = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      ptr_ff     <= ptr_in;
      cmp_idx_ff <= cmp_idx_in;
      key_ff     <= key_in;
      len_ff     <= len_in;
      res_ff     <= res_in;
   end

   // memory never read and written in the same cycle, so no forwarding is needed
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem.key_we || mem.total_we) |-> !mem.rd_en)
      else $error("memory read and write in the same cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_scan_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (ptr_ff <= count_ff))
      else $error("scan pointer ran past the valid entries");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> emit_ok)
      else $error("response produced while the output slot is busy");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(state_ff) == S_MISS) &&
      (count_ff == $past(count_ff) + 1'b1))
      else $error("entry count changed outside an insert");

endmodule

[src/mac_byte_accounting_table.sv]
// Per-MAC-address byte accounting table of TABLE_DEPTH entries. A record request whose
// transmitter or receiver address is all-ones is dropped; otherwise the selected address
// (upper three bytes only in vendor mode) is searched, accumulated with a saturating total,
// or appended, or refused when the table is full. Requests are handled one at a time: a record
// request occupies the block while the key memory read port scans the valid entries, one entry
// per cycle, until a match; a read request or a dropped packet needs no scan. A new request is
// taken while the previous response waits in the output register. The memories need no
// clearing after reset, only entries below the valid count are ever read.
//
// depends on mbat_pkg, mbat_if, mbat_ram and mbat_ctrl

module mac_byte_accounting_table import mbat_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mbat_req_if.sink              req_chan,
   mbat_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type            cfg_ff, cfg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               emit_ok;
   logic               emit_valid;
   rsp_type            emit_data;
   mem_req_type        mem;
   logic [MAC_W-1:0]   key_rdata;
   logic [TOTAL_W-1:0] total_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_USE_RECEIVER: cfg_in.use_receiver = csr_wr_data[0];
            CSR_VENDOR_ONLY:  cfg_in.vendor_only  = csr_wr_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // output register: free when empty or taken this cycle
   assign emit_ok      = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = emit_valid || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_data_in  = emit_valid ? emit_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   mbat_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_data    (req_chan.data),
      .emit_ok     (emit_ok),
      .emit_valid  (emit_valid),
      .emit_data   (emit_data),
      .mem         (mem),
      .key_rdata   (key_rdata),
      .total_rdata (total_rdata)
   );

   mbat_ram #(
      .WIDTH (MAC_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (mem.key_we),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.key_wdata),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (key_rdata)
   );

   mbat_ram #(
      .WIDTH (TOTAL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_total_ram (
      .clock   (clock),
      .wr_en   (mem.total_we),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.total_wdata),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (total_rdata)
   );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking regression of mac_byte_accounting_table, with its own table predictor
// depends on mbat_pkg, mbat_if and the mac_byte_accounting_table top level

module tb import mbat_pkg::*; ();

   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int MAX_REPORTS = 10;
   localparam int POOL_SIZE   = 24;
   localparam int MAX_WAIT    = 6;

   localparam logic [MAC_W-1:0] HOME_KEY   = 48'h0012_3456_789A;
   localparam logic [MAC_W-1:0] PEER_MAC   = 48'h00AB_CDEF_0123;
   localparam logic [MAC_W-1:0] NEAR_BCAST = 48'hFFFF_FFFF_FFFE;
   localparam logic [MAC_W-1:0] NO_MAC     = 48'h0;

   typedef struct packed {
      req_type     request;
      logic        typed;
      rsp_type     outcome;
      logic [16:0] copies;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   mbat_req_if req_chan ();
   mbat_rsp_if rsp_chan ();

   mac_byte_accounting_table DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predicted table contents and mode
   logic [MAC_W-1:0]   key_table   [TABLE_DEPTH];
   logic [TOTAL_W-1:0] total_table [TABLE_DEPTH];
   int                 stored_entries = 0;
   cfg_type            mode = '0;

   rsp_type          expected_results [$];
   directed_row_type directed_rows [$];
   logic [MAC_W-1:0] address_pool [POOL_SIZE];
   int               error_count   = 0;
   int               hold_request  = 0;
   int unsigned      cycle_count   = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("mac_byte_accounting_table regression: fail");
      $finish;
   end

   function automatic rsp_type account_request(input req_type q);
      rsp_type          r;
      logic [MAC_W-1:0] key;
      logic [TOTAL_W:0] sum;
      int               pos;
      r   = '0;
      pos = 0;
      if (q.operation == OP_READ) begin
         r.status      = STAT_READ;
         r.entry_index = q.read_index;
         if (int'(q.read_index) >= stored_entries) begin
            r.index_invalid = 1'b1;
         end else begin
            r.entry_mac   = key_table[q.read_index];
            r.entry_total = total_table[q.read_index];
         end
      end else if (q.transmitter_mac == MAC_BROADCAST || q.receiver_mac == MAC_BROADCAST) begin
         r.status = STAT_BROADCAST;
      end else begin
         key = mode.use_receiver ? q.receiver_mac : q.transmitter_mac;
         if (mode.vendor_only) key = key & VENDOR_MASK;
         while (pos < stored_entries && key_table[pos] != key) pos++;
         r.entry_mac = key;
         if (pos < stored_entries) begin
            sum = {1'b0, total_table[pos]} + (TOTAL_W + 1)'(q.byte_count);
            if (sum > {1'b0, TOTAL_MAX}) sum = {1'b0, TOTAL_MAX};
            total_table[pos] = sum[TOTAL_W-1:0];
            r.status      = STAT_ACCUMULATED;
            r.entry_index = OIDX_W'(pos);
            r.entry_total = sum[TOTAL_W-1:0];
         end else if (stored_entries >= TABLE_DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            key_table[pos]   = key;
            total_table[pos] = TOTAL_W'(q.byte_count);
            stored_entries++;
            r.status      = STAT_INSERTED;
            r.entry_index = OIDX_W'(pos);
            r.entry_total = TOTAL_W'(q.byte_count);
         end
      end
      r.entry_count = OCNT_W'(stored_entries);
      return r;
   endfunction

   function automatic string describe(input rsp_type r);
      return $sformatf("status=%0d index=%0d mac=%012h total=%08h count=%0d invalid=%0b",
                       r.status, r.entry_index, r.entry_mac, r.entry_total, r.entry_count,
                       r.index_invalid);
   endfunction

   function automatic logic [MAC_W-1:0] random_mac();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[MAC_W-1:0];
   endfunction

   // mostly known stations, some strangers, broadcast and near-broadcast now and then
   function automatic logic [MAC_W-1:0] pick_address();
      logic [MAC_W-1:0] mac;
      case ($urandom_range(0, 11))
         0, 1, 2, 3, 4, 5, 6: mac = address_pool[$urandom_range(0, POOL_SIZE - 1)];
         7, 8:                mac = random_mac();
         9:                   mac = MAC_BROADCAST;
         10:                  mac = MAC_BROADCAST ^ (48'd1 << $urandom_range(0, MAC_W - 1));
         default: begin
            // known vendor, new station
            mac = random_mac();
            mac[MAC_W-1:24] = address_pool[$urandom_range(0, POOL_SIZE - 1)][MAC_W-1:24];
         end
      endcase
      return mac;
   endfunction

   function automatic req_type random_request();
      req_type q;
      q.operation       = ($urandom_range(0, 4) == 0) ? OP_READ : OP_RECORD;
      q.transmitter_mac = pick_address();
      q.receiver_mac    = pick_address();
      case ($urandom_range(0, 7))
         0:       q.byte_count = '0;
         1:       q.byte_count = '1;
         default: q.byte_count = LEN_W'($urandom);
      endcase
      if (q.operation == OP_READ && stored_entries > 0 && $urandom_range(0, 3) != 0)
         q.read_index = RIDX_W'($urandom_range(0, stored_entries - 1));
      else
         q.read_index = RIDX_W'($urandom);
      return q;
   endfunction

   function automatic void add_row(input req_type q, input logic typed, input rsp_type outcome,
                                   input int copies);
      directed_row_type row;
      row.request = q;
      row.typed   = typed;
      row.outcome = outcome;
      row.copies  = 17'(copies);
      directed_rows.push_back(row);
   endfunction

   task automatic set_mode(input logic use_rx, input logic vendor);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_USE_RECEIVER;
      csr_wr_data <= use_rx;
      @(posedge clock);
      csr_index   <= CSR_VENDOR_ONLY;
      csr_wr_data <= vendor;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mode.use_receiver = use_rx;
      mode.vendor_only  = vendor;
   endtask

   // valid stays up between back-to-back requests
   task automatic send_request(input req_type q, input logic typed, input rsp_type outcome);
      int      gap;
      rsp_type predicted;
      gap = $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= q;
      do @(posedge clock); while (!req_chan.ready);
      predicted = account_request(q);
      expected_results.push_back(typed ? outcome : predicted);
   endtask

   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic run_random(input int count);
      repeat (count) send_request(random_request(), 1'b0, '0);
   endtask

   // response side
   initial begin
      int      stall;
      rsp_type got;
      rsp_type want;
      rsp_chan.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = $urandom_range(0, MAX_WAIT) + hold_request;
         hold_request = 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got = rsp_chan.data;
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("cycle %0d: response with no request pending: %s",
                        cycle_count, describe(got));
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status || got.entry_index !== want.entry_index ||
                got.entry_mac !== want.entry_mac || got.entry_total !== want.entry_total ||
                got.entry_count !== want.entry_count ||
                got.index_invalid !== want.index_invalid) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("cycle %0d: response mismatch", cycle_count);
                  $display("   expected %s", describe(want));
                  $display("   actual   %s", describe(got));
               end
            end
         end
      end
   end

   initial begin
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_USE_RECEIVER;
      csr_wr_data    <= '0;
      foreach (address_pool[i]) address_pool[i] = random_mac();

      // empty table: reads at both ends are out of range
      add_row({OP_READ, HOME_KEY, PEER_MAC, 16'hFFFF, 10'd0}, 1'b1,
              {STAT_READ, 10'd0, NO_MAC, 32'd0, 11'd0, 1'b1}, 1);
      add_row({OP_READ, HOME_KEY, PEER_MAC, 16'h0000, 10'd1023}, 1'b1,
              {STAT_READ, 10'd1023, NO_MAC, 32'd0, 11'd0, 1'b1}, 1);
      // broadcast on either side, and on both
      add_row({OP_RECORD, MAC_BROADCAST, PEER_MAC, 16'd100, 10'd0}, 1'b1,
              {STAT_BROADCAST, 10'd0, NO_MAC, 32'd0, 11'd0, 1'b0}, 1);
      add_row({OP_RECORD, HOME_KEY, MAC_BROADCAST, 16'hFFFF, 10'h3FF}, 1'b1,
              {STAT_BROADCAST, 10'd0, NO_MAC, 32'd0, 11'd0, 1'b0}, 1);
      add_row({OP_RECORD, MAC_BROADCAST, MAC_BROADCAST, 16'hFFFF, 10'h3FF}, 1'b1,
              {STAT_BROADCAST, 10'd0, NO_MAC, 32'd0, 11'd0, 1'b0}, 1);
      // one station with full-size and empty packets
      add_row({OP_RECORD, HOME_KEY, PEER_MAC, 16'hFFFF, 10'd0}, 1'b1,
              {STAT_INSERTED, 10'd0, HOME_KEY, 32'h0000_FFFF, 11'd1, 1'b0}, 1);
      add_row({OP_RECORD, HOME_KEY, PEER_MAC, 16'hFFFF, 10'd0}, 1'b1,
              {STAT_ACCUMULATED, 10'd0, HOME_KEY, 32'h0001_FFFE, 11'd1, 1'b0}, 1);
      add_row({OP_RECORD, HOME_KEY, PEER_MAC, 16'hFFFF, 10'd0}, 1'b1,
              {STAT_ACCUMULATED, 10'd0, HOME_KEY, 32'h0002_FFFD, 11'd1, 1'b0}, 1);
      add_row({OP_RECORD, HOME_KEY, PEER_MAC, 16'h0000, 10'd0}, 1'b1,
              {STAT_ACCUMULATED, 10'd0, HOME_KEY, 32'h0002_FFFD, 11'd1, 1'b0}, 1);
      add_row({OP_READ, NO_MAC, NO_MAC, 16'h0000, 10'd0}, 1'b1,
              {STAT_READ, 10'd0, HOME_KEY, 32'h0002_FFFD, 11'd1, 1'b0}, 1);
      add_row({OP_READ, NO_MAC, NO_MAC, 16'h0000, 10'd1}, 1'b1,
              {STAT_READ, 10'd1, NO_MAC, 32'd0, 11'd1, 1'b1}, 1);
      // one bit short of broadcast is an ordinary station, as is all-zero
      add_row({OP_RECORD, NEAR_BCAST, NEAR_BCAST, 16'h0000, 10'd0}, 1'b1,
              {STAT_INSERTED, 10'd1, NEAR_BCAST, 32'd0, 11'd2, 1'b0}, 1);
      add_row({OP_RECORD, NO_MAC, NEAR_BCAST, 16'h0001, 10'd0}, 1'b1,
              {STAT_INSERTED, 10'd2, NO_MAC, 32'd1, 11'd3, 1'b0}, 1);
      add_row({OP_RECORD, NO_MAC, PEER_MAC, 16'hFFFF, 10'd0}, 1'b1,
              {STAT_ACCUMULATED, 10'd2, NO_MAC, 32'h0001_0000, 11'd3, 1'b0}, 1);
      add_row({OP_RECORD, 48'h8000_0000_0001, 48'h7FFF_FFFF_FFFF, 16'h8000, 10'h2AA},
              1'b0, '0, 1);
      add_row({OP_RECORD, PEER_MAC, HOME_KEY, 16'h5555, 10'h155}, 1'b0, '0, 1);
      add_row({OP_READ, NO_MAC, NO_MAC, 16'h0000, 10'd2}, 1'b1,
              {STAT_READ, 10'd2, NO_MAC, 32'h0001_0000, 11'd5, 1'b0}, 1);
      add_row({OP_READ, MAC_BROADCAST, MAC_BROADCAST, 16'hFFFF, 10'd4}, 1'b0, '0, 1);
      add_row({OP_READ, NO_MAC, NO_MAC, 16'h0000, 10'd5}, 1'b1,
              {STAT_READ, 10'd5, NO_MAC, 32'd0, 11'd5, 1'b1}, 1);
      add_row({OP_READ, NO_MAC, NO_MAC, 16'h0000, 10'd1023}, 1'b1,
              {STAT_READ, 10'd1023, NO_MAC, 32'd0, 11'd5, 1'b1}, 1);
      add_row({OP_RECORD, HOME_KEY, NO_MAC, 16'h0001, 10'd0}, 1'b1,
              {STAT_ACCUMULATED, 10'd0, HOME_KEY, 32'h0002_FFFE, 11'd5, 1'b0}, 1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_mode(1'b0, 1'b0);

      foreach (directed_rows[r]) begin
         repeat (directed_rows[r].copies)
            send_request(directed_rows[r].request, directed_rows[r].typed,
                         directed_rows[r].outcome);
      end
      drain_responses();

      set_mode(1'b1, 1'b0);
      run_random(140);
      drain_responses();

      // receiver goes quiet for a while so the block backs up into the request side
      set_mode(1'b0, 1'b1);
      hold_request = 400;
      run_random(140);
      drain_responses();

      set_mode(1'b1, 1'b1);
      run_random(140);
      drain_responses();

      set_mode(1'b0, 1'b0);
      run_random(140);
      drain_responses();

      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("mac_byte_accounting_table regression: pass");
      else
         $display("mac_byte_accounting_table regression: fail");
      $finish;
   end

endmodule
